FILE: rtl/rgb_pixel_point_effects_defines.svh
// ---------------------------------------------------------------------------
// rgb pixel point effects: assertion macros
// clocked property checks, with and without the reset qualifier
// ---------------------------------------------------------------------------
`ifndef RGB_PIXEL_POINT_EFFECTS_DEFINES_SVH
`define RGB_PIXEL_POINT_EFFECTS_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property checked on every rising edge outside reset
`define RGBPE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define RGBPE_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define RGBPE_ASSERT(label, prop, msg)
`define RGBPE_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

FILE: rtl/rgbpe_pkg.sv
// ---------------------------------------------------------------------------
// rgb pixel point effects package
// effect codes, register indexes and the sepia arithmetic helpers
// ---------------------------------------------------------------------------
package rgbpe_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int SUM_BITS     = 19;
	localparam int TDATA_BITS   = 3 * CHANNEL_BITS;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_BITS     = 9;
	localparam int LEVEL_BITS   = 9;

	localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = '1;

	typedef enum logic [1:0] {
		MODE_GRAY      = 2'd0,
		MODE_SEPIA     = 2'd1,
		MODE_NEGATIVE  = 2'd2,
		MODE_THRESHOLD = 2'd3
	} effect_mode_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_EFFECT_MODE     = 2'd0,
		REG_MAX_DEPTH       = 2'd1,
		REG_THRESHOLD_LEVEL = 2'd2,
		REG_UNUSED          = 2'd3
	} cfg_reg_t;

	// sepia matrix in thousandths, one row per output channel
	localparam logic [9:0] SEPIA_COEF [3][3] = '{
		'{10'd393, 10'd769, 10'd189},
		'{10'd349, 10'd686, 10'd168},
		'{10'd272, 10'd534, 10'd131}
	};

	// floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every x below 493447,
	// which covers every sepia sum (at most 1351 * 255 = 344505)
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_BITS  = 19;
	localparam logic [RECIP_BITS-1:0] RECIP_1000 = RECIP_BITS'((2 ** RECIP_SHIFT) / 1000 + 1);
	localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
	localparam int QUOT_BITS   = CHANNEL_BITS + 1;

	// weighted channel sum of one sepia row, exact in 19 bits
	function automatic logic [SUM_BITS-1:0] sepia_sum(
		input logic [1:0]              row,
		input logic [CHANNEL_BITS-1:0] r,
		input logic [CHANNEL_BITS-1:0] g,
		input logic [CHANNEL_BITS-1:0] b
	);
		logic [SUM_BITS-1:0] pr;
		logic [SUM_BITS-1:0] pg;
		logic [SUM_BITS-1:0] pb;
		pr = SUM_BITS'(SEPIA_COEF[row][0]) * SUM_BITS'(r);
		pg = SUM_BITS'(SEPIA_COEF[row][1]) * SUM_BITS'(g);
		pb = SUM_BITS'(SEPIA_COEF[row][2]) * SUM_BITS'(b);
		return pr + pg + pb;
	endfunction

	// divide by 1000 with truncation, saturate at full scale
	function automatic logic [CHANNEL_BITS-1:0] div1000_sat(input logic [SUM_BITS-1:0] sum);
		logic [PROD_BITS-1:0] prod;
		logic [QUOT_BITS-1:0] quot;
		prod = PROD_BITS'(sum) * PROD_BITS'(RECIP_1000);
		quot = prod[RECIP_SHIFT +: QUOT_BITS];
		return quot[QUOT_BITS-1] ? CHAN_MAX : quot[CHANNEL_BITS-1:0];
	endfunction

endpackage

FILE: rtl/rgb_pixel_point_effects.sv
// ---------------------------------------------------------------------------
// rgb pixel point effects
// per-pixel gray, sepia, negative and threshold effects on an rgb stream
// ---------------------------------------------------------------------------
// One 24-bit rgb pixel enters per beat and one transformed pixel leaves per
// beat, one pixel per clock when the output side keeps taking. On the way
// from the input beat to the output beat an input stage registers the
// pixel with its three sepia weighted sums, and a result stage registers the
// finished pixel. The single reciprocal multiply per channel that turns a
// sepia sum into its quotient by 1000 sits between the two stages and sets
// the clock period. Both stages advance together whenever the result stage is
// empty or being taken; while a result waits the input still takes one more
// beat into the empty input stage and then stalls until the result is taken.
// Registers are written over a separate write channel that never stalls and
// must only be changed while no pixel is inside the block.

`include "rgb_pixel_point_effects_defines.svh"

module rgb_pixel_point_effects (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// pixel input
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [rgbpe_pkg::TDATA_BITS-1:0]        s_axis_tdata,  // red_in, green_in, blue_in
	// pixel output
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [rgbpe_pkg::TDATA_BITS-1:0]        m_axis_tdata,  // red_out, green_out, blue_out
	// register writes
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [rgbpe_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [rgbpe_pkg::CFG_BITS-1:0]          cfg_data
);

	localparam int CB = rgbpe_pkg::CHANNEL_BITS;
	localparam int SB = rgbpe_pkg::SUM_BITS;

	// configuration registers
	rgbpe_pkg::effect_mode_t           effect_mode_q;
	logic [CB-1:0]                     max_depth_q;
	logic [rgbpe_pkg::LEVEL_BITS-1:0]  threshold_level_q;

	// input stage: pixel plus precomputed sepia sums
	logic          valid_s1;
	logic [CB-1:0] chan_s1 [3];
	logic [SB-1:0] sum_s1  [3];

	// result stage
	logic          valid_s2;
	logic [CB-1:0] res_s2 [3];

	logic          adv_s2;
	logic          adv_s1;
	logic          in_beat;
	logic [CB-1:0] chan_in [3];
	logic [SB-1:0] sum_in  [3];
	logic [CB-1:0] top;
	logic [CB-1:0] res     [3];

	// register writes are taken at once; an index beyond the list is dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_mode_q     <= rgbpe_pkg::MODE_GRAY;
			max_depth_q       <= rgbpe_pkg::CHAN_MAX;
			threshold_level_q <= rgbpe_pkg::LEVEL_BITS'(128);
		end else if (cfg_valid && cfg_ready) begin
			unique case (rgbpe_pkg::cfg_reg_t'(cfg_index))
				rgbpe_pkg::REG_EFFECT_MODE: begin
					effect_mode_q <= rgbpe_pkg::effect_mode_t'(cfg_data[1:0]);
				end
				rgbpe_pkg::REG_MAX_DEPTH: begin
					max_depth_q <= cfg_data[CB-1:0];
				end
				rgbpe_pkg::REG_THRESHOLD_LEVEL: begin
					threshold_level_q <= cfg_data[rgbpe_pkg::LEVEL_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// pipeline flow: a stage moves when the one after it has room
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	// unpack the beat, red in the low byte
	assign chan_in[0] = s_axis_tdata[0*CB +: CB];
	assign chan_in[1] = s_axis_tdata[1*CB +: CB];
	assign chan_in[2] = s_axis_tdata[2*CB +: CB];

	// sepia weighted sums, constant coefficients only
	for (genvar k = 0; k < 3; k++) begin : g_sum
		assign sum_in[k] = rgbpe_pkg::sepia_sum(2'(k), chan_in[0], chan_in[1], chan_in[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			chan_s1 <= chan_in;
			sum_s1  <= sum_in;
		end
	end

	// hsv value: largest of the three channels
	always_comb begin
		top = (chan_s1[0] > chan_s1[1]) ? chan_s1[0] : chan_s1[1];
		top = (top > chan_s1[2]) ? top : chan_s1[2];
	end

	// effect selection
	always_comb begin
		unique case (effect_mode_q)
			rgbpe_pkg::MODE_GRAY: begin
				res[0] = top;
				res[1] = top;
				res[2] = top;
			end
			rgbpe_pkg::MODE_SEPIA: begin
				res[0] = rgbpe_pkg::div1000_sat(sum_s1[0]);
				res[1] = rgbpe_pkg::div1000_sat(sum_s1[1]);
				res[2] = rgbpe_pkg::div1000_sat(sum_s1[2]);
			end
			rgbpe_pkg::MODE_NEGATIVE: begin
				// wraps modulo 256 when a channel is above the depth
				res[0] = max_depth_q - chan_s1[0];
				res[1] = max_depth_q - chan_s1[1];
				res[2] = max_depth_q - chan_s1[2];
			end
			rgbpe_pkg::MODE_THRESHOLD: begin
				// levels above full scale turn every pixel black
				if ({1'b0, top} < threshold_level_q) begin
					res[0] = '0;
					res[1] = '0;
					res[2] = '0;
				end else begin
					res[0] = rgbpe_pkg::CHAN_MAX;
					res[1] = rgbpe_pkg::CHAN_MAX;
					res[2] = rgbpe_pkg::CHAN_MAX;
				end
			end
			default: begin
				res[0] = top;
				res[1] = top;
				res[2] = top;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2[2], res_s2[1], res_s2[0]};

	// checks

	// input stalls only with both stages holding a pixel
	`RGBPE_ASSERT(a_stall_full, !s_axis_tready |-> (valid_s1 && valid_s2), "input stalled with room inside")

	// gray and threshold give one value on all three channels
	`RGBPE_ASSERT(a_equal_chan, (m_axis_tvalid && (effect_mode_q == rgbpe_pkg::MODE_GRAY || effect_mode_q == rgbpe_pkg::MODE_THRESHOLD)) |-> (res_s2[0] == res_s2[1] && res_s2[1] == res_s2[2]), "channels differ in gray or threshold mode")

	// threshold gives only black or white
	`RGBPE_ASSERT(a_thresh_bw, (m_axis_tvalid && effect_mode_q == rgbpe_pkg::MODE_THRESHOLD) |-> (res_s2[0] == '0 || res_s2[0] == rgbpe_pkg::CHAN_MAX), "threshold result neither black nor white")

	// no output beat offered while in reset
	`RGBPE_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !m_axis_tvalid, "output valid during reset")

endmodule
